### rtl/bds_pkg.sv
// bds_pkg: shared constants, register indexes and the control/status
// structs between the search controller and the search datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bds_pkg;

   // Search limits
   localparam int unsigned MAX_DIVISOR = 255;
   localparam int unsigned CD_W        = $clog2(MAX_DIVISOR + 1);

   // Field widths
   localparam int unsigned CLOCK_W   = 29;
   localparam int unsigned TARGET_W  = 32;
   localparam int unsigned DIVISOR_W = 8;
   localparam int unsigned FRAC_W    = 3;
   localparam int unsigned RATE_W    = 29;
   localparam int unsigned FP_W      = 4;
   localparam int unsigned ERR_W     = TARGET_W + 1;

   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 40;

   // Divider: one quotient bit per cycle over the shifted numerator
   localparam int unsigned DIV_STEPS = RATE_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

   // Divisor start values and shifts (den = cd*128 async, cd*8 SPI)
   localparam logic [CD_W-1:0] CD_START_ASYNC = CD_W'(1);
   localparam logic [CD_W-1:0] CD_START_SPI   = CD_W'(6);
   localparam int unsigned     SHIFT_ASYNC    = 7;
   localparam int unsigned     SHIFT_SPI      = 3;
   localparam logic [FP_W-1:0] FP_FIRST       = FP_W'(8);
   localparam logic [FP_W-1:0] FP_LAST        = FP_W'(1);

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK_HZ = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPI_MODE = 1'b1;

   localparam logic [CLOCK_W-1:0] CLOCK_HZ_RESET = CLOCK_W'(48000000);

   typedef struct packed {
      logic init;      // latch target, reset best, first candidate
      logic div_load;  // load divider for current fp/cd
      logic div_step;  // one quotient bit
      logic eval;      // compare candidate, advance fp/cd
      logic out_load;  // move best into output register
   } ctl_type;

   typedef struct packed {
      logic div_last;    // divider takes its final step this cycle
      logic search_end;  // evaluated candidate ends the search
      logic out_free;    // output register can take a result
   } sts_type;

endpackage

`default_nettype wire

### rtl/baud_divisor_search_top.sv
// baud_divisor_search_top: fractional baud divisor search, top level.
// Depends on bds_pkg, bds_ctrl and bds_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Takes a target baud rate and returns the divisor/fraction pair whose rate
// comes closest, rate = clock_hz*fp / (cd*128) async or clock_hz*fp / (cd*8)
// SPI, fp from 8 down to 1, cd upward from 1 (async) or 6 (SPI) to 255. A
// strictly smaller error wins; a pass over cd ends once a non-improving rate
// falls below the target; an exact hit at fp 8 ends the search. Fraction 8
// is reported as 0. One request is searched at a time. Each candidate takes
// one load, 29 steps of the bit-serial quotient divider and one compare. A
// full search is up to 8 x 255 candidates. The result sits in an output
// register; the search finishes in the background and waits only if the
// previous result has not been taken. clock_hz and spi_mode are written
// through the csr_ port and must only change while no request is in
// flight.

module baud_divisor_search_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Configuration writes
   input  wire logic                              csr_we,
   input  wire logic [bds_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bds_pkg::CLOCK_W-1:0]       csr_wdata,
   // Request stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [bds_pkg::REQ_DATA_W-1:0]    req_tdata,  // [31:0] target_baud
   // Result stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [bds_pkg::RSP_DATA_W-1:0]         rsp_tdata   // [7:0] divisor,
                                                              // [10:8] fraction,
                                                              // [39:11] achieved_baud
);

   // Configuration registers
   logic [bds_pkg::CLOCK_W-1:0] clock_hz_ff;
   logic                        spi_mode_ff;

   bds_pkg::ctl_type ctl;
   bds_pkg::sts_type sts;

   logic [bds_pkg::DIVISOR_W-1:0] divisor;
   logic [bds_pkg::FRAC_W-1:0]    fraction;
   logic [bds_pkg::RATE_W-1:0]    achieved_baud;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= bds_pkg::CLOCK_HZ_RESET;
         spi_mode_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            bds_pkg::CSR_CLOCK_HZ: clock_hz_ff <= csr_wdata;
            bds_pkg::CSR_SPI_MODE: spi_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Sequencer: idle -> (load, divide, evaluate)* -> hand off result
   bds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .ctl       (ctl)
   );

   // Divider, best-pair registers and output register
   bds_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .sts          (sts),
      .clock_hz     (clock_hz_ff),
      .spi_mode     (spi_mode_ff),
      .target_baud  (req_tdata),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_divisor  (divisor),
      .out_fraction (fraction),
      .out_rate     (achieved_baud)
   );

   assign rsp_tdata = {achieved_baud, fraction, divisor};

endmodule

`default_nettype wire

### rtl/bds_ctrl.sv
// bds_ctrl: sequencer for the divisor search.
// Depends on bds_pkg (ctl_type, sts_type).
`timescale 1ns / 1ps
`default_nettype none

module bds_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  bds_pkg::sts_type     sts,
   output bds_pkg::ctl_type     ctl
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIVIDE,
      ST_EVAL,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.init = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            ctl.div_load = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            ctl.div_step = 1'b1;
            if (sts.div_last) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            ctl.eval = 1'b1;
            state_in = sts.search_end ? ST_FINISH : ST_LOAD;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               ctl.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/bds_datapath.sv
// bds_datapath: candidate rate divider, best-pair tracking and output register.
// Depends on bds_pkg (constants, ctl_type, sts_type).
`timescale 1ns / 1ps
`default_nettype none

module bds_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  bds_pkg::ctl_type                     ctl,
   output bds_pkg::sts_type                     sts,
   input  wire logic [bds_pkg::CLOCK_W-1:0]     clock_hz,
   input  wire logic                            spi_mode,
   input  wire logic [bds_pkg::TARGET_W-1:0]    target_baud,
   output logic                                 out_valid,
   input  wire logic                            out_ready,
   output logic [bds_pkg::DIVISOR_W-1:0]        out_divisor,
   output logic [bds_pkg::FRAC_W-1:0]           out_fraction,
   output logic [bds_pkg::RATE_W-1:0]           out_rate
);

   // Search position
   logic [bds_pkg::TARGET_W-1:0]  target_ff;
   logic [bds_pkg::FP_W-1:0]      fp_ff;
   logic [bds_pkg::CD_W-1:0]      cd_ff;
   logic [bds_pkg::CD_W-1:0]      cd_start;

   // Best so far
   logic [bds_pkg::ERR_W-1:0]     best_err_ff;
   logic [bds_pkg::CD_W-1:0]      best_cd_ff;
   logic [bds_pkg::FRAC_W-1:0]    best_fp_ff;
   logic [bds_pkg::RATE_W-1:0]    best_rate_ff;

   // Divider: quo_ff shifts numerator out and quotient in
   logic [bds_pkg::RATE_W-1:0]    quo_ff;
   logic [bds_pkg::CD_W-1:0]      rem_ff;
   logic [bds_pkg::DIV_CNT_W-1:0] cnt_ff;

   logic [bds_pkg::CLOCK_W+bds_pkg::FP_W-1:0] num;
   logic [bds_pkg::RATE_W-1:0]    num_shifted;
   logic [bds_pkg::CD_W:0]        trial;
   logic                          fits;

   logic [bds_pkg::TARGET_W-1:0]  rate_ext;
   logic [bds_pkg::TARGET_W-1:0]  err;
   logic                          improve;
   logic                          stop_all;
   logic                          inner_end;

   logic                          out_valid_ff;

   assign cd_start = spi_mode ? bds_pkg::CD_START_SPI : bds_pkg::CD_START_ASYNC;

   // floor(n / (cd << k)) == floor((n >> k) / cd)
   assign num         = {{bds_pkg::FP_W{1'b0}}, clock_hz}
                        * {{bds_pkg::CLOCK_W{1'b0}}, fp_ff};
   assign num_shifted = spi_mode ? bds_pkg::RATE_W'(num >> bds_pkg::SHIFT_SPI)
                                 : bds_pkg::RATE_W'(num >> bds_pkg::SHIFT_ASYNC);

   assign trial = {rem_ff, quo_ff[bds_pkg::RATE_W-1]};
   assign fits  = (trial >= {1'b0, cd_ff});

   // Candidate evaluation
   assign rate_ext  = bds_pkg::TARGET_W'(quo_ff);
   assign err       = (rate_ext >= target_ff) ? (rate_ext - target_ff)
                                              : (target_ff - rate_ext);
   assign improve   = ({1'b0, err} < best_err_ff);
   assign stop_all  = improve && (err == '0) && (fp_ff == bds_pkg::FP_FIRST);
   assign inner_end = (!improve && (rate_ext < target_ff))
                      || (cd_ff == bds_pkg::CD_W'(bds_pkg::MAX_DIVISOR));

   assign sts.div_last   = (cnt_ff == bds_pkg::DIV_CNT_W'(1));
   assign sts.search_end = stop_all || (inner_end && (fp_ff == bds_pkg::FP_LAST));
   assign sts.out_free   = !out_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (ctl.init) begin
         target_ff    <= target_baud;
         fp_ff        <= bds_pkg::FP_FIRST;
         cd_ff        <= cd_start;
         best_err_ff  <= {1'b1, {bds_pkg::TARGET_W{1'b0}}};
         best_cd_ff   <= cd_start;
         best_fp_ff   <= '0;
         best_rate_ff <= '0;
      end else if (ctl.eval) begin
         if (improve) begin
            best_err_ff  <= {1'b0, err};
            best_rate_ff <= quo_ff;
            best_cd_ff   <= cd_ff;
            best_fp_ff   <= bds_pkg::FRAC_W'(fp_ff);  // 8 wraps to 0
         end
         if (inner_end) begin
            fp_ff <= fp_ff - bds_pkg::FP_W'(1);
            cd_ff <= cd_start;
         end else begin
            cd_ff <= cd_ff + bds_pkg::CD_W'(1);
         end
      end

      if (ctl.div_load) begin
         quo_ff <= num_shifted;
         rem_ff <= '0;
         cnt_ff <= bds_pkg::DIV_CNT_W'(bds_pkg::DIV_STEPS);
      end else if (ctl.div_step) begin
         quo_ff <= {quo_ff[bds_pkg::RATE_W-2:0], fits};
         rem_ff <= fits ? bds_pkg::CD_W'(trial - {1'b0, cd_ff})
                        : bds_pkg::CD_W'(trial);
         cnt_ff <= cnt_ff - bds_pkg::DIV_CNT_W'(1);
      end

      if (ctl.out_load) begin
         out_divisor  <= bds_pkg::DIVISOR_W'(best_cd_ff);
         out_fraction <= best_fp_ff;
         out_rate     <= best_rate_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ctl.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign out_valid = out_valid_ff;

endmodule

`default_nettype wire

### tb/baud_pick_checker.sv
`timescale 1ns / 1ps
// baud_pick_checker: watches the csr_, req_ and rsp_ ports of the baud divisor search,
// predicts the divisor/fraction/rate for every target and compares each result transfer.
// Depends on bds_pkg for widths, register indexes and search limits.

module baud_pick_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [bds_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bds_pkg::CLOCK_W-1:0]       csr_wdata,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [bds_pkg::REQ_DATA_W-1:0]    req_tdata,  // [31:0] target_baud
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [bds_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [7:0] divisor, [10:8] fraction,
                                                         // [39:11] achieved_baud
   output int unsigned                       targets_seen,
   output int unsigned                       picks_seen,
   output int unsigned                       mismatches
);

   // same layout as rsp_tdata (first member lands in the top bits)
   typedef struct packed {
      logic [bds_pkg::RATE_W-1:0]    achieved_baud;
      logic [bds_pkg::FRAC_W-1:0]    fraction;
      logic [bds_pkg::DIVISOR_W-1:0] divisor;
   } baud_pick_type;

   logic [bds_pkg::CLOCK_W-1:0] cfg_clock_hz;
   logic                        cfg_spi;
   baud_pick_type               expected_picks[$];

   function automatic baud_pick_type closest_baud_pick(
      input logic [bds_pkg::TARGET_W-1:0] target,
      input logic [bds_pkg::CLOCK_W-1:0]  clk_hz,
      input logic                         spi
   );
      longint unsigned clk64, den, rate, err, best_err;
      int unsigned     fp, cd, first_cd, shift;
      bit              search_over, pass_over;
      baud_pick_type   pick;
      clk64    = clk_hz;
      first_cd = spi ? bds_pkg::CD_START_SPI : bds_pkg::CD_START_ASYNC;
      shift    = spi ? bds_pkg::SHIFT_SPI : bds_pkg::SHIFT_ASYNC;
      // above any 32-bit error: the first candidate always wins
      best_err = 64'd1 << bds_pkg::TARGET_W;
      pick.divisor       = first_cd[bds_pkg::DIVISOR_W-1:0];
      pick.fraction      = '0;
      pick.achieved_baud = '0;
      search_over = 1'b0;
      fp = bds_pkg::FP_FIRST;
      while (fp >= bds_pkg::FP_LAST && !search_over) begin
         cd = first_cd;
         pass_over = 1'b0;
         while (cd <= bds_pkg::MAX_DIVISOR && !pass_over && !search_over) begin
            den  = cd;
            den  = den << shift;
            rate = (clk64 * fp) / den;
            err  = (rate >= target) ? rate - target : target - rate;
            if (err < best_err) begin
               best_err           = err;
               pick.divisor       = cd[bds_pkg::DIVISOR_W-1:0];
               pick.fraction      = fp[bds_pkg::FRAC_W-1:0];  // 8 wraps to 0
               pick.achieved_baud = rate[bds_pkg::RATE_W-1:0];
               if (err == 0 && fp == bds_pkg::FP_FIRST)
                  search_over = 1'b1;
            end else if (rate < target) begin
               pass_over = 1'b1;
            end
            cd++;
         end
         fp--;
      end
      return pick;
   endfunction

   always @(posedge clock) begin
      baud_pick_type got, want;
      int unsigned   bad;
      if (reset) begin
         cfg_clock_hz = bds_pkg::CLOCK_HZ_RESET;
         cfg_spi      = 1'b0;
         expected_picks.delete();
         targets_seen <= 0;
         picks_seen   <= 0;
         mismatches   <= 0;
      end else begin
         bad = 0;
         if (csr_we) begin
            if (csr_index == bds_pkg::CSR_CLOCK_HZ)
               cfg_clock_hz = csr_wdata;
            else if (csr_index == bds_pkg::CSR_SPI_MODE)
               cfg_spi = csr_wdata[0];
         end
         if (req_tvalid && req_tready) begin
            expected_picks.push_back(closest_baud_pick(req_tdata, cfg_clock_hz, cfg_spi));
            targets_seen <= targets_seen + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            picks_seen <= picks_seen + 1;
            if (expected_picks.size() == 0) begin
               $display("%0t: result transfer with nothing outstanding: expected none, got %h",
                        $time, rsp_tdata);
               bad++;
            end else begin
               want = expected_picks.pop_front();
               if (got.divisor !== want.divisor) begin
                  $display("%0t: divisor expected %0d, got %0d",
                           $time, want.divisor, got.divisor);
                  bad++;
               end
               if (got.fraction !== want.fraction) begin
                  $display("%0t: fraction expected %0d, got %0d",
                           $time, want.fraction, got.fraction);
                  bad++;
               end
               if (got.achieved_baud !== want.achieved_baud) begin
                  $display("%0t: achieved_baud expected %0d, got %0d",
                           $time, want.achieved_baud, got.achieved_baud);
                  bad++;
               end
            end
         end
         mismatches <= mismatches + bad;
      end
   end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// tb: stimulus and verdict for baud_divisor_search_top; drives targets, register
// settings and result back-pressure. Depends on bds_pkg, the RTL and baud_pick_checker.

module tb;

   localparam int unsigned RESET_CYCLES    = 12;
   localparam int unsigned RANDOM_PHASES   = 8;
   localparam int unsigned ITEMS_PER_PHASE = 12;
   localparam int unsigned HOLD_ITEMS      = 8;
   localparam int unsigned HOLD_CYCLES     = 4000;
   localparam int unsigned SETTLE_CYCLES   = 40;
   // Worst case per transfer: a full search of 8 x 255 candidates,
   // plus the longest gap on both sides. Bound on transfers sent, times 3.
   localparam longint unsigned ITEM_BOUND  = 140;
   localparam longint unsigned WORST_ITEM  = 2 + 31 * 8 * bds_pkg::MAX_DIVISOR + 40;
   localparam longint unsigned CYCLE_LIMIT = 3 * ITEM_BOUND * WORST_ITEM
                                             + HOLD_CYCLES + 1000;

   logic                              clock;
   logic                              reset       = 1'b1;
   logic                              csr_we      = 1'b0;
   logic [bds_pkg::CSR_IDX_W-1:0]     csr_index   = bds_pkg::CSR_CLOCK_HZ;
   logic [bds_pkg::CLOCK_W-1:0]       csr_wdata   = '0;
   logic                              req_tvalid  = 1'b0;
   logic                              req_tready;
   logic [bds_pkg::REQ_DATA_W-1:0]    req_tdata   = '0;    // [31:0] target_baud
   logic                              rsp_tvalid;
   logic                              rsp_tready  = 1'b0;
   logic [bds_pkg::RSP_DATA_W-1:0]    rsp_tdata;           // [7:0] divisor, [10:8] fraction,
                                                           // [39:11] achieved_baud

   // handshakes between the stimulus and the result-side process
   logic hold_window = 1'b0;   // receiver takes its one long hold-off
   logic calm        = 1'b0;   // final stretch: no stalls on either side

   int unsigned targets_seen, picks_seen, mismatches;

   // stimulus-side state
   bit                          sender_quiet = 1'b0;
   logic [bds_pkg::CLOCK_W-1:0] cur_clock_hz = bds_pkg::CLOCK_HZ_RESET;
   logic                        cur_spi      = 1'b0;
   int unsigned                 settings_used = 1;
   longint unsigned             cycles = 0;

   baud_divisor_search_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   baud_pick_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .targets_seen (targets_seen),
      .picks_seen   (picks_seen),
      .mismatches   (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d targets sent, %0d results back",
               cycles, targets_seen, picks_seen);
      $display("CHECKS FAILED");
      $finish;
   end

   // Result side: random stall bursts, occasional stall-free stretches, and one
   // long hold-off so the search and its output register back up into req_tready.
   initial begin : rsp_side
      bit          hold_done;
      int unsigned roll;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         roll = $urandom_range(0, 63);
         if (hold_window && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && roll < 8) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else if (!calm && roll == 63) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(50, 300)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // One target transfer; returns at the edge where it was taken, tvalid still high
   // so a back-to-back transfer needs no second assignment in that step.
   task automatic send_target(input logic [bds_pkg::TARGET_W-1:0] target);
      if (!sender_quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= target;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop offering and wait until every target has its result. The first edge lets
   // the checker's counts catch up with a transfer taken at the current edge.
   task automatic wait_for_picks();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (targets_seen != picks_seen) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Both registers, back to back; only called with nothing in flight.
   task automatic configure(input logic [bds_pkg::CLOCK_W-1:0] clk_hz, input logic spi);
      csr_we    <= 1'b1;
      csr_index <= bds_pkg::CSR_CLOCK_HZ;
      csr_wdata <= clk_hz;
      @(posedge clock);
      csr_index <= bds_pkg::CSR_SPI_MODE;
      csr_wdata <= {{(bds_pkg::CLOCK_W-1){1'b0}}, spi};
      @(posedge clock);
      csr_we <= 1'b0;
      cur_clock_hz = clk_hz;
      cur_spi      = spi;
      settings_used++;
   endtask

   // Mostly targets close to a real candidate with a small divisor, so each search
   // crosses over early; the rest are wide random values, uniform picks and near-top rates.
   function automatic logic [bds_pkg::TARGET_W-1:0] random_target(
      input logic [bds_pkg::CLOCK_W-1:0] clk_hz,
      input logic                        spi
   );
      longint unsigned clk64, den, rate, top_rate;
      int unsigned     first_cd, shift, cd, fp, kind, nudge;
      clk64    = clk_hz;
      first_cd = spi ? bds_pkg::CD_START_SPI : bds_pkg::CD_START_ASYNC;
      shift    = spi ? bds_pkg::SHIFT_SPI : bds_pkg::SHIFT_ASYNC;
      den      = first_cd;
      top_rate = (clk64 * bds_pkg::FP_FIRST) / (den << shift);
      kind     = $urandom_range(0, 19);
      if (kind < 12) begin
         cd    = $urandom_range(first_cd, first_cd + 24);
         fp    = $urandom_range(bds_pkg::FP_LAST, bds_pkg::FP_FIRST);
         den   = cd;
         rate  = (clk64 * fp) / (den << shift);
         nudge = $urandom_range(0, 3);
         case ($urandom_range(0, 2))
            0:       return rate[bds_pkg::TARGET_W-1:0];
            1:       return rate[bds_pkg::TARGET_W-1:0] + nudge;
            default: return (rate > nudge) ? rate[bds_pkg::TARGET_W-1:0] - nudge : '0;
         endcase
      end else if (kind < 15) begin
         return $urandom;
      end else if (kind < 18) begin
         return $urandom_range(0, top_rate[bds_pkg::TARGET_W-1:0]);
      end else begin
         // right at or just above the fastest candidate: an exact hit ends the search at once
         return top_rate[bds_pkg::TARGET_W-1:0] + $urandom_range(0, 5);
      end
   endfunction

   initial begin : stimulus
      logic [31:0]                 rnd;
      logic [bds_pkg::CLOCK_W-1:0] clk_hz;
      logic                        spi;
      int unsigned                 phase, n;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings (48 MHz, async), no register write yet.
      send_target(32'd3_000_000);    // exact at divisor 1, fraction 8
      send_target(32'd375_000);      // exact at divisor 8
      send_target(32'd115_200);
      send_target(32'd2_999_999);
      send_target(32'd3_000_001);    // above every candidate
      send_target(32'hFFFF_FFFF);    // largest target
      send_target(32'h8000_0000);
      send_target(32'd0);            // every rate above target: full search of all pairs
      wait_for_picks();

      // Largest clock in SPI mode; search starts at divisor 6.
      configure({bds_pkg::CLOCK_W{1'b1}}, 1'b1);
      send_target(32'hFFFF_FFFF);
      send_target(32'd89_478_485);   // exact at divisor 6, fraction 8
      send_target(32'd5_000_000);
      send_target(32'd12_345_678);
      wait_for_picks();

      // Smallest legal clock: every rate is 0, first candidate stands.
      configure(29'd1, 1'b0);
      send_target(32'd0);
      send_target(32'd1);
      send_target(32'h5A5A_5A5A);
      wait_for_picks();

      // Clock of zero.
      configure('0, 1'b1);
      send_target(32'd0);
      send_target(32'd7);
      wait_for_picks();

      // Small clock in SPI mode: 5000/cd.
      configure(29'd5000, 1'b1);
      send_target(32'd833);          // exact at divisor 6
      send_target(32'd100);
      send_target(32'd834);
      wait_for_picks();

      // Random settings, alternating async and SPI; last phase runs without stalls.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == RANDOM_PHASES - 1) begin
            calm <= 1'b1;
            sender_quiet = 1'b1;
         end
         rnd = $urandom;
         if (phase == 0) begin
            clk_hz = {bds_pkg::CLOCK_W{1'b1}};
         end else begin
            case ($urandom_range(0, 4))
               0:       clk_hz = rnd[bds_pkg::CLOCK_W-1:0];
               1:       clk_hz = $urandom_range(1, 20_000);
               2:       clk_hz = $urandom_range(1_000_000, 200_000_000);
               3:       clk_hz = $urandom_range(1, 16);
               default: clk_hz = rnd[bds_pkg::CLOCK_W-1:0] | 29'h1000_0000;
            endcase
         end
         spi = phase[0];
         configure(clk_hz, spi);

         if (phase == 2) begin
            // Cheap searches (target above every rate) while the receiver holds off.
            hold_window <= 1'b1;
            for (n = 0; n < HOLD_ITEMS; n++)
               send_target($urandom_range(32'h8000_0000, 32'hFFFF_FFFF));
         end
         for (n = 0; n < ITEMS_PER_PHASE; n++)
            send_target(random_target(cur_clock_hz, cur_spi));
         wait_for_picks();
      end

      $display("Covered %0d target transfers under %0d register settings", targets_seen,
               settings_used);
      $display("(async and SPI, clock 0 up to full width); %0d results compared", picks_seen);
      if (mismatches == 0 && targets_seen == picks_seen) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### sim.f
rtl/bds_pkg.sv
rtl/bds_ctrl.sv
rtl/bds_datapath.sv
rtl/baud_divisor_search_top.sv
tb/baud_pick_checker.sv
tb/tb.sv
